FILE: rtl/bpgc_pkg.sv
`default_nettype none

package bpgc_pkg;

	// event codes
	localparam logic [1:0] EV_SINGLE = 2'd0;
	localparam logic [1:0] EV_HOLD   = 2'd1;
	localparam logic [1:0] EV_DOUBLE = 2'd2;

	// register indexes
	localparam int         CFG_IDX_W  = 3;
	localparam int         CFG_DATA_W = 20;
	localparam logic [2:0] CFG_BOUNCE = 3'd0;
	localparam logic [2:0] CFG_HOLD   = 3'd1;
	localparam logic [2:0] CFG_DOUBLE = 3'd2;
	localparam logic [2:0] CFG_ON     = 3'd3;
	localparam logic [2:0] CFG_OFF    = 3'd4;

	// register reset values
	localparam logic [15:0] BOUNCE_RST = 16'd50;
	localparam logic [15:0] HOLD_RST   = 16'd250;
	localparam logic [15:0] DOUBLE_RST = 16'd500;
	localparam logic [19:0] ON_RST     = 20'hCF20D;
	localparam logic [19:0] OFF_RST    = 20'hC728D;

	// result queue depth, at least 2
	localparam int OQ_DEPTH = 4;

	typedef struct packed {
		logic        level;
		logic [31:0] now_ms;
	} btn_in_t;

	typedef struct packed {
		logic [1:0]  event_res;
		logic [19:0] ir_code;
		logic        last;
	} btn_out_t;

	// up to two results pushed per item
	typedef struct packed {
		logic [1:0] cnt;
		btn_out_t   r0;
		btn_out_t   r1;
	} oq_push_t;

endpackage

`default_nettype wire

FILE: rtl/bpgc_core.sv
`default_nettype none

module bpgc_core #(
	parameter int Depth = bpgc_pkg::OQ_DEPTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire bpgc_pkg::btn_in_t             in_data,
	input  wire logic                          cfg_we,
	input  wire logic [bpgc_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  wire logic [bpgc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic [$clog2(Depth+1)-1:0]    room,
	output bpgc_pkg::oq_push_t                 push
);

	localparam int CntW = $clog2(Depth+1);

	// config
	logic [15:0] bounce_q, hold_ms_q, double_q;
	logic [19:0] on_code_q, off_code_q;

	// input stage
	logic              valid_s1;
	bpgc_pkg::btn_in_t item_s1;

	// classifier state
	logic        prev_q, hold_q, pend_q;
	logic [31:0] press_q, sw_q;

	logic        rise, held, fall, cnt_ok, is_double, single_fire, adv;
	logic [31:0] dt_press, dt_sw;
	bpgc_pkg::oq_push_t res;

	always_comb begin
		rise      = item_s1.level & ~prev_q;
		held      = item_s1.level & prev_q;
		fall      = ~item_s1.level & prev_q;
		dt_press  = item_s1.now_ms - press_q;
		dt_sw     = item_s1.now_ms - sw_q;
		cnt_ok    = fall && (dt_press > {16'd0, bounce_q}) && !hold_q;
		is_double = cnt_ok && (dt_sw < {16'd0, double_q});
		// counted release moves the switch time to now, so no timeout then
		single_fire = !cnt_ok && pend_q && (dt_sw > {16'd0, double_q});

		res = '0;
		if (fall && hold_q) begin
			res.r0 = '{event_res: bpgc_pkg::EV_HOLD, ir_code: off_code_q,
				last: !single_fire};
			if (single_fire) begin
				res.r1  = '{event_res: bpgc_pkg::EV_SINGLE, ir_code: on_code_q,
					last: 1'b1};
				res.cnt = 2'd2;
			end else begin
				res.cnt = 2'd1;
			end
		end else if (is_double) begin
			res.r0  = '{event_res: bpgc_pkg::EV_DOUBLE, ir_code: '0, last: 1'b1};
			res.cnt = 2'd1;
		end else if (single_fire) begin
			res.r0  = '{event_res: bpgc_pkg::EV_SINGLE, ir_code: on_code_q,
				last: 1'b1};
			res.cnt = 2'd1;
		end
	end

	assign adv      = valid_s1 && (CntW'(res.cnt) <= room);
	assign in_ready = !valid_s1 || adv;
	assign push     = adv ? res : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bounce_q   <= bpgc_pkg::BOUNCE_RST;
			hold_ms_q  <= bpgc_pkg::HOLD_RST;
			double_q   <= bpgc_pkg::DOUBLE_RST;
			on_code_q  <= bpgc_pkg::ON_RST;
			off_code_q <= bpgc_pkg::OFF_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				bpgc_pkg::CFG_BOUNCE: bounce_q   <= cfg_wdata[15:0];
				bpgc_pkg::CFG_HOLD:   hold_ms_q  <= cfg_wdata[15:0];
				bpgc_pkg::CFG_DOUBLE: double_q   <= cfg_wdata[15:0];
				bpgc_pkg::CFG_ON:     on_code_q  <= cfg_wdata;
				bpgc_pkg::CFG_OFF:    off_code_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= 1'b0;
			hold_q  <= 1'b0;
			pend_q  <= 1'b0;
			press_q <= '0;
			sw_q    <= '0;
		end else if (adv) begin
			prev_q <= item_s1.level;
			if (rise) begin
				press_q <= item_s1.now_ms;
			end
			if (held && (dt_press > {16'd0, hold_ms_q})) begin
				hold_q <= 1'b1;
			end else if (fall) begin
				hold_q <= 1'b0;
			end
			if (cnt_ok) begin
				sw_q   <= item_s1.now_ms;
				pend_q <= !is_double;
			end else if (single_fire) begin
				pend_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/bpgc_oq.sv
`default_nettype none

module bpgc_oq #(
	parameter int Depth = bpgc_pkg::OQ_DEPTH
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire bpgc_pkg::oq_push_t         push,
	output logic [$clog2(Depth+1)-1:0]      room,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output bpgc_pkg::btn_out_t              out_data
);

	localparam int AW   = $clog2(Depth);
	localparam int CntW = $clog2(Depth+1);

	bpgc_pkg::btn_out_t mem_q [Depth];
	logic [AW-1:0]   wp_q, rp_q, wp1, wp2, rp1;
	logic [CntW-1:0] cnt_q;
	logic            pop;

	always_comb begin
		wp1 = (wp_q == AW'(Depth-1)) ? '0 : wp_q + 1'b1;
		wp2 = (wp1 == AW'(Depth-1)) ? '0 : wp1 + 1'b1;
		rp1 = (rp_q == AW'(Depth-1)) ? '0 : rp_q + 1'b1;
	end

	assign pop       = out_valid && out_ready;
	assign out_valid = (cnt_q != '0);
	assign out_data  = mem_q[rp_q];
	assign room      = CntW'(Depth) - cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			case (push.cnt)
				2'd1:    wp_q <= wp1;
				2'd2:    wp_q <= wp2;
				default: ;
			endcase
			if (pop) begin
				rp_q <= rp1;
			end
			cnt_q <= cnt_q + CntW'(push.cnt) - CntW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wp_q] <= push.r0;
		end
		if (push.cnt == 2'd2) begin
			mem_q[wp1] <= push.r1;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/button_press_gesture_classifier.sv
// Button gesture classifier: single, double and long (hold) press.
// Input channel (in_valid/in_ready/in_data): one beat per button sample,
// carrying the level and a wrapping 32-bit millisecond timestamp.
// Output channel (out_valid/out_ready/out_data): one beat per event; a
// sample causes zero, one or two events, and last marks its final event.
// Config port (cfg_we/cfg_addr/cfg_wdata): single-cycle register writes,
// to be done only while no sample is in flight.
// Path: input register, classify logic, then the event queue registers.
// Throughput: one sample per cycle while the queue has room; two-event
// samples take two output beats. Rate is set by the single input register
// feeding classify logic and the 4-entry queue draining one beat a cycle.
// Stall: while out_ready is low the queue fills; the input register holds
// its sample until the queue has room for all its events, and in_ready
// then drops, so nothing is lost or repeated.
// Reset (arst_n low): registers return to their defaults, button state is
// released, queue is emptied.
`default_nettype none

module button_press_gesture_classifier #(
	parameter int OqDepth = bpgc_pkg::OQ_DEPTH
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire bpgc_pkg::btn_in_t               in_data,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output bpgc_pkg::btn_out_t                   out_data,
	input  wire logic                            cfg_we,
	input  wire logic [bpgc_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  wire logic [bpgc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	// free queue slots, compared against the event count of the held sample
	logic [$clog2(OqDepth+1)-1:0] room;
	bpgc_pkg::oq_push_t           push;

	// input register, gesture state machine and config registers
	bpgc_core #(
		.Depth (OqDepth)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.room      (room),
		.push      (push)
	);

	// event queue; takes up to two events in one cycle, hands out one a beat
	bpgc_oq #(
		.Depth (OqDepth)
	) u_oq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

FILE: rtl/bpgc_chk.sv
`default_nettype none

module bpgc_chk (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire bpgc_pkg::btn_out_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");

	a_double_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.event_res == bpgc_pkg::EV_DOUBLE
		|-> out_data.ir_code == '0 && out_data.last)
		else $error("double press must carry zero code and end its sample");

	a_only_hold_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last |-> out_data.event_res == bpgc_pkg::EV_HOLD)
		else $error("only a hold release can precede another event");

	a_hold_then_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.last
		|=> out_valid && out_data.event_res == bpgc_pkg::EV_SINGLE && out_data.last)
		else $error("hold release not followed by its single press event");

endmodule

bind button_press_gesture_classifier bpgc_chk u_bpgc_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

`default_nettype wire

FILE: tb/sv/tb_button_press_gesture_classifier.sv
`timescale 1ns / 1ps

module tb_button_press_gesture_classifier;

	// ---------------------------------------------------------------
	// Clock and reset
	// ---------------------------------------------------------------
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always #5 clk = ~clk;

	// ---------------------------------------------------------------
	// DUT ports, all inputs driven to known values from time zero
	// ---------------------------------------------------------------
	logic                            in_valid  = 1'b0;
	logic                            in_ready;
	bpgc_pkg::btn_in_t               in_data   = '0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	bpgc_pkg::btn_out_t              out_data;
	logic                            cfg_we    = 1'b0;
	logic [bpgc_pkg::CFG_IDX_W-1:0]  cfg_addr  = '0;
	logic [bpgc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

	button_press_gesture_classifier u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	// ---------------------------------------------------------------
	// Shadow registers and button state of the gesture predictor
	// ---------------------------------------------------------------
	logic [15:0] cf_bounce = bpgc_pkg::BOUNCE_RST;
	logic [15:0] cf_hold   = bpgc_pkg::HOLD_RST;
	logic [15:0] cf_double = bpgc_pkg::DOUBLE_RST;
	logic [19:0] cf_on     = bpgc_pkg::ON_RST;
	logic [19:0] cf_off    = bpgc_pkg::OFF_RST;

	logic        st_prev   = 1'b0;   // last sampled level
	logic        st_hold   = 1'b0;   // press has gone past hold limit
	logic        st_pend   = 1'b0;   // single press armed, waiting out window
	logic [31:0] st_press  = '0;     // time of last rising edge
	logic [31:0] st_switch = '0;     // time of last counted release

	bpgc_pkg::btn_in_t  sample_q[$];     // samples waiting for the driver
	bpgc_pkg::btn_out_t exp_events[$];   // predicted events, oldest first
	bpgc_pkg::btn_out_t ev_want;

	int          n_queued = 0;     // samples handed to the driver
	int          n_taken  = 0;     // sample beats accepted by the DUT
	bit          failed   = 1'b0;
	logic [31:0] t_now    = '0;    // running timestamp of the generator

	// sender burst / gap bookkeeping
	int tx_burst = 0;
	int tx_gap   = 0;

	// receiver stall pattern
	int       rx_mode = 0;
	bit [5:0] rx_cnt  = '0;

	// ---------------------------------------------------------------
	// Gesture predictor: one accepted sample in, 0..2 events queued
	// ---------------------------------------------------------------
	task automatic classify_sample(input bpgc_pkg::btn_in_t s);
		bpgc_pkg::btn_out_t ev[2];
		int                 n;
		logic [31:0]        t;
		logic [31:0]        el_press;
		logic [31:0]        el_switch;
		n = 0;
		t = s.now_ms;

		// rising edge captures press time
		if (s.level && !st_prev)
			st_press = t;

		// still held: check against hold limit (modular elapsed time)
		el_press = t - st_press;
		if (s.level && st_prev && el_press > 32'(cf_hold))
			st_hold = 1'b1;

		// falling edge
		if (!s.level && st_prev) begin
			el_switch = t - st_switch;
			if (el_press > 32'(cf_bounce) && !st_hold) begin
				if (el_switch >= 32'(cf_double)) begin
					st_pend = 1'b1;
				end else begin
					st_pend          = 1'b0;
					ev[n].event_res  = bpgc_pkg::EV_DOUBLE;
					ev[n].ir_code    = '0;
					ev[n].last       = 1'b0;
					n++;
				end
				st_switch = t;
			end
			if (st_hold) begin
				ev[n].event_res = bpgc_pkg::EV_HOLD;
				ev[n].ir_code   = cf_off;
				ev[n].last      = 1'b0;
				n++;
				st_hold = 1'b0;
			end
		end

		st_prev = s.level;

		// armed single whose window has run out
		el_switch = t - st_switch;
		if (st_pend && el_switch > 32'(cf_double)) begin
			ev[n].event_res = bpgc_pkg::EV_SINGLE;
			ev[n].ir_code   = cf_on;
			ev[n].last      = 1'b0;
			n++;
			st_pend = 1'b0;
		end

		if (n > 0)
			ev[n-1].last = 1'b1;
		for (int i = 0; i < n; i++)
			exp_events.push_back(ev[i]);
	endtask

	// ---------------------------------------------------------------
	// Driver: bursts of sample beats with random gaps in between.
	// Prediction happens on the edge where a beat is accepted.
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				classify_sample(in_data);
				n_taken++;
			end
			// only move on when the current beat is gone (or there is none)
			if (!in_valid || in_ready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					in_valid <= 1'b0;
				end else if (sample_q.size() > 0) begin
					in_data  <= sample_q.pop_front();
					in_valid <= 1'b1;
					if (tx_burst == 0) begin
						// a quarter of the bursts run back to back with no gap
						tx_burst = $urandom_range(1, 24);
						tx_gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						tx_burst--;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Monitor: receiver stalls on a pattern picked anew whenever rx_cnt wraps
	// (always ready, coin flip, 1 in 4, follows rx_cnt[3]); each event beat is
	// checked against the oldest prediction.
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (exp_events.size() == 0) begin
					$error("unexpected event beat: event_res %0d ir_code %05h last %0b",
						out_data.event_res, out_data.ir_code, out_data.last);
					failed = 1'b1;
				end else begin
					ev_want = exp_events.pop_front();
					if (out_data.event_res !== ev_want.event_res) begin
						$error("event_res: expected %0d, actual %0d",
							ev_want.event_res, out_data.event_res);
						failed = 1'b1;
					end
					if (out_data.ir_code !== ev_want.ir_code) begin
						$error("ir_code: expected %05h, actual %05h",
							ev_want.ir_code, out_data.ir_code);
						failed = 1'b1;
					end
					if (out_data.last !== ev_want.last) begin
						$error("last: expected %0b, actual %0b", ev_want.last, out_data.last);
						failed = 1'b1;
					end
				end
			end

			rx_cnt = rx_cnt + 1'b1;
			if (rx_cnt == 0)
				rx_mode = $urandom_range(0, 3);
			case (rx_mode)
				0:       out_ready <= 1'b1;
				1:       out_ready <= 1'($urandom_range(0, 1));
				2:       out_ready <= (rx_cnt[1:0] == 2'd0);
				default: out_ready <= rx_cnt[3];
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------
	task automatic queue_sample(input bit lvl, input logic [31:0] t);
		bpgc_pkg::btn_in_t s;
		s.level  = lvl;
		s.now_ms = t;
		sample_q.push_back(s);
		n_queued++;
	endtask

	// elapsed time biased toward a threshold: just below, on, just above,
	// or anywhere within a couple of windows
	function automatic logic [31:0] near_limit(input logic [31:0] lim);
		case ($urandom_range(0, 5))
			0:       return (lim == 0) ? 32'd0 : lim - 1;
			1:       return lim;
			2:       return lim + 1;
			3:       return $urandom_range(0, lim);
			4:       return lim + $urandom_range(0, lim + 2);
			default: return $urandom_range(0, 8);
		endcase
	endfunction

	// one press: rising edge, some held samples, release
	task automatic press_gesture();
		logic [31:0] t0;
		logic [31:0] ht;
		int          nh;
		// gap since last release, sometimes around the double window
		if ($urandom_range(0, 2) == 0)
			t_now += near_limit(32'(cf_double));
		else
			t_now += $urandom_range(0, 32'(cf_bounce) + 4);
		t0 = t_now;
		queue_sample(1'b1, t0);
		nh = $urandom_range(0, 3);
		ht = t0;
		for (int i = 0; i < nh; i++) begin
			ht += $urandom_range(0, 32'(cf_hold) / 2 + 1);
			queue_sample(1'b1, ht);
		end
		// a held sample right at the hold limit
		if ($urandom_range(0, 1))
			queue_sample(1'b1, t0 + near_limit(32'(cf_hold)));
		if ($urandom_range(0, 1))
			t_now = t0 + near_limit(32'(cf_bounce));
		else
			t_now = t0 + near_limit(32'(cf_hold));
		queue_sample(1'b0, t_now);
	endtask

	task automatic cfg_write(input logic [bpgc_pkg::CFG_IDX_W-1:0] idx,
		input logic [bpgc_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			bpgc_pkg::CFG_BOUNCE: cf_bounce = val[15:0];
			bpgc_pkg::CFG_HOLD:   cf_hold   = val[15:0];
			bpgc_pkg::CFG_DOUBLE: cf_double = val[15:0];
			bpgc_pkg::CFG_ON:     cf_on     = val;
			bpgc_pkg::CFG_OFF:    cf_off    = val;
			default:              ;
		endcase
	endtask

	// every beat accepted and every event seen, then a wait for samples that
	// cause no event and may still sit in the pipe
	task automatic wait_drained();
		while (n_taken != n_queued || exp_events.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		int phase_end;
		logic [bpgc_pkg::CFG_DATA_W-1:0] v_b, v_h, v_d, v_on, v_off;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed part, reset register values (50 / 250 / 500)
		queue_sample(1'b0, 32'h0000_0000);   // idle at time zero
		queue_sample(1'b1, 32'hFFFF_FF00);   // press near top of range
		queue_sample(1'b0, 32'hFFFF_FF32);   // release after exactly bounce: too short
		queue_sample(1'b1, 32'hFFFF_FFF0);
		queue_sample(1'b1, 32'hFFFF_FFFF);   // held at max timestamp
		queue_sample(1'b0, 32'h0000_0050);   // release across the wrap, inside double window
		queue_sample(1'b0, 32'h0000_0100);
		queue_sample(1'b1, 32'h0000_1000);   // clean tap arms a single
		queue_sample(1'b0, 32'h0000_1064);
		queue_sample(1'b0, 32'h0000_1258);   // window exactly reached: still pending
		queue_sample(1'b0, 32'h0000_1259);   // window passed: power on
		queue_sample(1'b1, 32'h0000_2000);   // tap arms a single ...
		queue_sample(1'b0, 32'h0000_2080);
		queue_sample(1'b1, 32'h0000_2100);   // ... then a hold
		queue_sample(1'b1, 32'h0000_21FA);   // exactly hold limit: not yet a hold
		queue_sample(1'b1, 32'h0000_21FB);   // one past: hold
		queue_sample(1'b0, 32'h0000_2300);   // power off, then expired single power on
		queue_sample(1'b1, 32'h0000_3000);   // two taps close together: double
		queue_sample(1'b0, 32'h0000_3040);
		queue_sample(1'b1, 32'h0000_3100);
		queue_sample(1'b0, 32'h0000_3140);
		queue_sample(1'b1, 32'h0000_5000);   // timestamp runs backwards on release
		queue_sample(1'b0, 32'h0000_4000);
		queue_sample(1'b0, 32'h0000_0000);   // backwards again, single times out
		t_now = 32'h0000_0000;
		wait_drained();

		// random phases, each with its own register setting
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin   // all minimum
					v_b = '0; v_h = '0; v_d = '0; v_on = '0; v_off = '0;
				end
				1: begin   // all ones, upper bits masked on 16-bit registers
					v_b = '1; v_h = '1; v_d = '1; v_on = '1; v_off = '1;
				end
				2: begin   // short windows
					v_b = 20'd3; v_h = 20'd20; v_d = 20'd40;
					v_on = 20'($urandom()); v_off = 20'($urandom());
				end
				3: begin
					v_b = 20'(bpgc_pkg::BOUNCE_RST);
					v_h = 20'(bpgc_pkg::HOLD_RST);
					v_d = 20'(bpgc_pkg::DOUBLE_RST);
					v_on = 20'($urandom()); v_off = 20'($urandom());
				end
				default: begin
					v_b = 20'($urandom()); v_h = 20'($urandom()); v_d = 20'($urandom());
					v_on = 20'($urandom()); v_off = 20'($urandom());
				end
			endcase
			cfg_write(bpgc_pkg::CFG_BOUNCE, v_b);
			cfg_write(bpgc_pkg::CFG_HOLD, v_h);
			cfg_write(bpgc_pkg::CFG_DOUBLE, v_d);
			cfg_write(bpgc_pkg::CFG_ON, v_on);
			cfg_write(bpgc_pkg::CFG_OFF, v_off);
			// unused indexes must not touch anything
			for (int i = bpgc_pkg::CFG_OFF + 1; i < (1 << bpgc_pkg::CFG_IDX_W); i++)
				cfg_write(bpgc_pkg::CFG_IDX_W'(i), 20'($urandom()));

			phase_end = n_queued + 300;
			while (n_queued < phase_end) begin
				case ($urandom_range(0, 19))
					0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: press_gesture();
					12, 13, 14, 15, 16: begin
						// released idle time, lets a pending single expire
						t_now += near_limit(32'(cf_double));
						queue_sample(1'b0, t_now);
					end
					default: begin
						// noise: any level, any timestamp
						t_now = $urandom();
						queue_sample(1'($urandom_range(0, 1)), t_now);
					end
				endcase
			end
			wait_drained();
		end

		repeat (8) @(posedge clk);
		if (exp_events.size() != 0) begin
			$error("%0d predicted events never arrived", exp_events.size());
			failed = 1'b1;
		end
		if (!failed)
			$display("button_press_gesture_classifier: match");
		else
			$display("button_press_gesture_classifier: mismatch");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#(5_000_000);
		$display("button_press_gesture_classifier: mismatch");
		$finish;
	end

endmodule
